### hw/rtl/tbb_pkg.sv
// shared types, constants and pass-geometry functions of the triple box blur row filter
package tbb_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 13;
  localparam int POS_W     = 13;
  localparam int M_W       = 14;
  localparam int BOX_W     = 5;
  localparam int OFF_W     = 4;
  localparam int WIN_DEPTH = 32;
  localparam int NUM_PASS  = 3;
  localparam logic [BOX_W-1:0] MIN_BOX = 5'd2;
  localparam logic [BOX_W-1:0] MAX_BOX = 5'd21;
  localparam logic [BOX_W-1:0] BOX_RST = 5'd3;
  localparam logic [POS_W-1:0] POS_CAP = {POS_W{1'b1}};

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             end_of_row;
  } tbb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_out;
  } tbb_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_EMIT,
    ST_NEXT
  } tbb_state_t;

  typedef struct packed {
    logic load_in;
    logic step;
    logic div_step;
    logic emit;
    logic fs_inc;
    logic flush_feed;
    logic finish;
  } tbb_cmd_t;

  typedef struct packed {
    logic gate;
    logic div_last;
    logic s_last;
    logic out_free;
    logic eor;
    logic fs_done;
    logic fk_end;
  } tbb_stat_t;

  function automatic logic [BOX_W-1:0] clamp_box(input logic [BOX_W-1:0] b);
    logic [BOX_W-1:0] r;
    r = b;
    if (b < MIN_BOX) r = MIN_BOX;
    if (b > MAX_BOX) r = MAX_BOX;
    return r;
  endfunction

  function automatic logic [BOX_W-1:0] pass_width(input logic [BOX_W-1:0] d,
                                                   input logic [1:0] s);
    logic [BOX_W-1:0] r;
    r = d;
    if (!d[0] && s == 2'd2) r = d + 5'd1;
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] pass_offset(input logic [BOX_W-1:0] d,
                                                    input logic [1:0] s);
    logic [OFF_W-1:0] h;
    logic [OFF_W-1:0] r;
    h = d[BOX_W-1:1];
    case (s)
      2'd0:    r = d[0] ? h : h - 4'd1;
      2'd1:    r = h;
      2'd2:    r = h;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/triple_box_blur_row.sv
// top level of the triple box blur row filter
// an accepted beat runs, per pass it reaches, 1 window step and then the divider
// (one quotient bit a cycle in the shared restoring divider); after the third pass its result is
// emitted once the output register is free, and only after that is the next beat taken
// a beat held back by a pass offset frees the input without emitting a result; an end-of-row beat
// also runs one zero feed per pass offset, up to 30; results leave through a one-deep register
// rst_n is synchronous: windows and sums clear, box size returns to 3
module triple_box_blur_row (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tbb_pkg::tbb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tbb_pkg::tbb_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_data
);
  import tbb_pkg::*;

  tbb_cmd_t  cmd;
  tbb_stat_t stat;

  assign cfg_ready = 1'b1;

  tbb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tbb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/tbb_ctrl.sv
// sequencing state machine of the triple box blur row filter
module tbb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tbb_pkg::tbb_stat_t stat,
  output logic              in_stall,
  output tbb_pkg::tbb_cmd_t  cmd
);
  import tbb_pkg::*;

  tbb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        state_nxt = stat.gate ? ST_NEXT : ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_last) state_nxt = stat.s_last ? ST_EMIT : ST_STEP;
      end
      ST_EMIT: begin
        if (stat.out_free) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (!stat.eor || stat.fs_done) state_nxt = ST_IDLE;
        else if (!stat.fk_end) state_nxt = ST_STEP;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_STEP: cmd.step = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_EMIT: cmd.emit = stat.out_free;
      ST_NEXT: begin
        if (!stat.eor || stat.fs_done) cmd.finish = 1'b1;
        else if (stat.fk_end) cmd.fs_inc = 1'b1;
        else cmd.flush_feed = 1'b1;
      end
      default: ;
    endcase
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> (state_r == ST_STEP)) else $error("accepted beat not stepped");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free) else $error("emit without room");

endmodule

### hw/rtl/tbb_dp.sv
// windows, sums, divider and output register of the triple box blur row filter
module tbb_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  tbb_pkg::tbb_cmd_t  cmd,
  input  tbb_pkg::tbb_in_t   in_data,
  input  logic               cfg_valid,
  input  logic [4:0]         cfg_data,
  input  logic               out_stall,
  output tbb_pkg::tbb_stat_t stat,
  output logic               out_valid,
  output tbb_pkg::tbb_out_t  out_data
);
  import tbb_pkg::*;

  logic [BOX_W-1:0] box_size_r;
  logic [BOX_W-1:0] row_d_r;
  logic [POS_W-1:0] row_pos_r;
  logic [POS_W-1:0] pos_r;
  logic             eor_r;
  logic [PIX_W-1:0] v_r;
  logic [M_W-1:0]   m_r;
  logic [1:0]       s_r;
  logic [1:0]       fs_r;
  logic [OFF_W-1:0] fk_r;
  logic             last_pend_r;
  logic [M_W-1:0]   rem_r;
  logic [PIX_W-1:0] q_r;
  logic [2:0]       cnt_r;
  logic [PIX_W-1:0] win_r [NUM_PASS][WIN_DEPTH];
  logic [SUM_W-1:0] sum_r [NUM_PASS];
  logic             out_valid_r;
  tbb_out_t         out_r;

  logic [BOX_W-1:0] cur_w;
  logic [OFF_W-1:0] cur_off;
  logic [OFF_W-1:0] fs_off;
  logic [BOX_W-1:0] leave_idx;
  logic [PIX_W-1:0] leave;
  logic [SUM_W-1:0] sum_new;
  logic [M_W-1:0]   div_x;
  logic [M_W-1:0]   wsh;
  logic             ge;
  logic [PIX_W-1:0] q_nxt;
  logic [M_W-1:0]   rem_nxt;
  logic             out_free;

  assign cur_w     = pass_width(row_d_r, s_r);
  assign cur_off   = pass_offset(row_d_r, s_r);
  assign fs_off    = pass_offset(row_d_r, fs_r);
  assign leave_idx = cur_w - 5'd1;
  assign leave     = win_r[s_r][leave_idx];
  assign sum_new   = sum_r[s_r] + {5'b0, v_r} - {5'b0, leave};
  assign div_x     = {1'b0, sum_new} + {10'b0, cur_w[BOX_W-1:1]};
  assign wsh       = {9'b0, cur_w} << cnt_r;
  assign ge        = rem_r >= wsh;
  assign rem_nxt   = ge ? rem_r - wsh : rem_r;
  assign q_nxt     = q_r | (ge ? (8'd1 << cnt_r) : 8'd0);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    stat          = '0;
    stat.gate     = m_r < {10'b0, cur_off};
    stat.div_last = cnt_r == 3'd0;
    stat.s_last   = s_r == 2'd2;
    stat.out_free = out_free;
    stat.eor      = eor_r;
    stat.fs_done  = fs_r == 2'd3;
    stat.fk_end   = fk_r >= fs_off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_size_r  <= BOX_RST;
      row_d_r     <= BOX_RST;
      row_pos_r   <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_PASS; p++) begin
        sum_r[p] <= '0;
        for (int k = 0; k < WIN_DEPTH; k++) win_r[p][k] <= '0;
      end
    end else begin
      if (cfg_valid) box_size_r <= cfg_data;
      if (cmd.load_in && row_pos_r == '0) row_d_r <= clamp_box(box_size_r);
      if (cmd.step) begin
        for (int k = WIN_DEPTH - 1; k > 0; k--) win_r[s_r][k] <= win_r[s_r][k-1];
        win_r[s_r][0] <= v_r;
        sum_r[s_r]    <= sum_new;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cmd.finish) begin
        if (eor_r) begin
          row_pos_r <= '0;
          for (int p = 0; p < NUM_PASS; p++) begin
            sum_r[p] <= '0;
            for (int k = 0; k < WIN_DEPTH; k++) win_r[p][k] <= '0;
          end
        end else if (row_pos_r != POS_CAP) begin
          row_pos_r <= row_pos_r + 13'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_r         <= in_data.pixel_in;
      eor_r       <= in_data.end_of_row;
      pos_r       <= row_pos_r;
      m_r         <= {1'b0, row_pos_r};
      s_r         <= 2'd0;
      fs_r        <= 2'd0;
      fk_r        <= '0;
      last_pend_r <= 1'b0;
    end
    if (cmd.step) begin
      rem_r <= div_x;
      q_r   <= '0;
      cnt_r <= 3'd7;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        v_r <= q_nxt;
        m_r <= m_r - {10'b0, cur_off};
        s_r <= s_r + 2'd1;
      end
    end
    if (cmd.fs_inc) begin
      fs_r <= fs_r + 2'd1;
      fk_r <= '0;
    end
    if (cmd.flush_feed) begin
      s_r         <= fs_r;
      v_r         <= '0;
      m_r         <= {1'b0, pos_r} + 14'd1 + {10'b0, fk_r};
      fk_r        <= fk_r + 4'd1;
      last_pend_r <= (fs_r == 2'd2) && (fk_r == fs_off - 4'd1);
    end
    if (cmd.emit) begin
      out_r.pixel_out <= v_r;
      out_r.last_out  <= last_pend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall)) else $error("result overwritten");
  a_step_pass: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (s_r != 2'd3)) else $error("step beyond last pass");
  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && eor_r) |=> (row_pos_r == '0)) else $error("row not cleared");

endmodule
